// ===== rtl/core/cwtt_pkg.sv =====
// Package for the operation word to text converter.
// Holds field widths, the per-stage item type and the BCD and letter helpers.
// No dependencies.
package cwtt_pkg;

    localparam int WORD_W      = 32;
    localparam int CODE_W      = 4;
    localparam int RUN_W       = WORD_W - CODE_W;
    localparam int DIG_N       = 9;
    localparam int CNT_W       = 4;
    localparam int N_STAGES    = 4;
    localparam int STEPS_PER_STAGE = RUN_W / N_STAGES;
    localparam int NUM_OPS     = 9;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [3:0]        CHAR_DIGIT_HI = 4'h3;

    typedef logic [DIG_N-1:0][3:0] t_bcd;

    typedef struct packed {
        logic [RUN_W-1:0]  bin;
        t_bcd              bcd;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_item;

    function automatic t_item dabble_step(input t_item it);
        t_item r;
        r = it;
        for (int d = 0; d < DIG_N; d++) begin
            if (r.bcd[d] >= 4'd5) begin
                r.bcd[d] = r.bcd[d] + 4'd3;
            end
        end
        r.bcd = {r.bcd[DIG_N-1][2:0], r.bcd[DIG_N-2:0], r.bin[RUN_W-1]};
        r.bin = {r.bin[RUN_W-2:0], 1'b0};
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] op_letter(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            4'd0:    c = "M";
            4'd1:    c = "I";
            4'd2:    c = "D";
            4'd3:    c = "N";
            4'd4:    c = "S";
            4'd5:    c = "H";
            4'd6:    c = "P";
            4'd7:    c = "=";
            4'd8:    c = "X";
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/cwtt_bcd_pipe.sv =====
// Pipelined binary to BCD conversion of the run length, several shift-add3
// steps per register stage. Depends on cwtt_pkg.
module cwtt_bcd_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cwtt_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output cwtt_pkg::t_item o_item
);
    import cwtt_pkg::*;

    logic  [N_STAGES-1:0] r_valid;
    t_item                r_item [N_STAGES];
    logic  [N_STAGES-1:0] w_en;
    logic  [N_STAGES-1:0] w_vin;
    t_item                w_in   [N_STAGES];
    t_item                n_item [N_STAGES];

    always_comb begin
        for (int k = 0; k < N_STAGES; k++) begin
            if (k == 0) begin
                w_vin[k] = i_valid;
                w_in[k]  = i_item;
            end else begin
                w_vin[k] = r_valid[k-1];
                w_in[k]  = r_item[k-1];
            end
        end
        for (int k = N_STAGES - 1; k >= 0; k--) begin
            if (k == N_STAGES - 1) begin
                w_en[k] = !r_valid[k] || i_ready;
            end else begin
                w_en[k] = !r_valid[k] || w_en[k+1];
            end
        end
        for (int k = 0; k < N_STAGES; k++) begin
            n_item[k] = w_in[k];
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                n_item[k] = dabble_step(n_item[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_STAGES; k++) begin
            if (w_en[k]) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_valid[N_STAGES-1];
    assign o_item  = r_item[N_STAGES-1];

endmodule

// ===== rtl/core/cigar_word_to_text.sv =====
// Top level of the operation word to text converter.
// Depends on cwtt_pkg and cwtt_bcd_pipe.
//
// Each input transfer carries one packed operation word (code in bits 3..0, run
// length in bits 31..4) and tlast marking the final operation of a record. The
// block sends the run length as decimal ASCII digits without leading zeros, the
// operation letter for codes 0 to 8, and a NUL byte after the final operation of
// a record; codes 9 to 15 send no digits or letter. One character leaves per
// cycle while the output is not stalled, with tlast on the last character of
// each word. A word yields from 0 to 11 characters; one that yields nothing
// passes the BCD stages but is never loaded into the serializer. Each word
// goes through four BCD conversion stages, the serializer and the output
// register before its first character leaves.
module cigar_word_to_text (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cwtt_pkg::WORD_W-1:0]   s_axis_tdata,  // cigar_word
    input  logic                          s_axis_tlast,  // last_of_record
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cwtt_pkg::CHAR_W-1:0]   m_axis_tdata,  // text_char
    output logic                          m_axis_tlast   // last_of_item
);
    import cwtt_pkg::*;

    t_item             w_in_item;
    t_item             w_p_item;
    logic              w_p_valid;
    logic              w_ser_ready;
    logic              w_out_free;
    logic              w_emit;
    logic              w_final;
    logic [CNT_W-1:0]  w_nd;
    logic              w_code_ok;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_dsel;
    logic [CHAR_W-1:0] w_char;

    logic              r_sv;
    t_bcd              r_bcd;
    logic [CNT_W-1:0]  r_nd;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic              r_code_ok;
    logic [CODE_W-1:0] r_code;

    logic              r_ov;
    logic [CHAR_W-1:0] r_od;
    logic              r_ol;

    always_comb begin
        w_in_item.bin  = s_axis_tdata[WORD_W-1:CODE_W];
        w_in_item.bcd  = '0;
        w_in_item.code = s_axis_tdata[CODE_W-1:0];
        w_in_item.last = s_axis_tlast;
    end

    cwtt_bcd_pipe u_bcd_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_p_valid),
        .i_ready (w_ser_ready),
        .o_item  (w_p_item)
    );

    always_comb begin
        w_nd = CNT_W'(1);
        for (int d = 0; d < DIG_N; d++) begin
            if (w_p_item.bcd[d] != 4'd0) begin
                w_nd = CNT_W'(d + 1);
            end
        end
        w_code_ok = (w_p_item.code < CODE_W'(NUM_OPS));
        if (w_code_ok) begin
            w_cnt = w_nd + CNT_W'(1) + CNT_W'(w_p_item.last);
        end else begin
            w_cnt = CNT_W'(w_p_item.last);
        end
    end

    assign w_out_free  = !r_ov || m_axis_tready;
    assign w_emit      = r_sv && w_out_free;
    assign w_final     = (r_idx == r_cnt - CNT_W'(1));
    assign w_ser_ready = !r_sv || (w_emit && w_final);

    always_comb begin
        w_dsel = r_nd - CNT_W'(1) - r_idx;
        if (r_code_ok && (r_idx < r_nd)) begin
            w_char = {CHAR_DIGIT_HI, r_bcd[w_dsel]};
        end else if (r_code_ok && (r_idx == r_nd)) begin
            w_char = op_letter(r_code);
        end else begin
            w_char = CHAR_NUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_ser_ready) begin
                r_sv  <= w_p_valid && (w_cnt != '0);
                r_idx <= '0;
            end else if (w_emit) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (w_out_free) begin
                r_ov <= r_sv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_ready) begin
            r_bcd     <= w_p_item.bcd;
            r_nd      <= w_nd;
            r_cnt     <= w_cnt;
            r_code_ok <= w_code_ok;
            r_code    <= w_p_item.code;
        end
        if (w_out_free) begin
            r_od <= w_char;
            r_ol <= w_final;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_idx < r_cnt))
        else $error("serializer index past character count");

    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && r_code_ok) |-> (r_nd >= CNT_W'(1) && r_nd <= CNT_W'(DIG_N)))
        else $error("digit count out of range");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_p_valid && !w_ser_ready) |=> (w_p_valid && $stable(w_p_item)))
        else $error("pipeline output lost while serializer busy");

    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_final) |=> (r_ov && r_ol))
        else $error("final character not marked last");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for cigar_word_to_text: packed operation words in, text characters out.
// Runs a directed table, then random records, and checks every character against a local predictor.
// Depends on cwtt_pkg and the cigar_word_to_text RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cwtt_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RST_CYCLES   = 8;
    localparam int RAND_ITEMS   = 250;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 40;
    localparam int IDLE_PCT     = 36;
    localparam int STEADY_FROM  = 1500;
    localparam int STEADY_TO    = 2500;
    localparam logic [RUN_W-1:0] MAX_RUN = '1;

    typedef enum logic [CODE_W-1:0] {
        OP_M         = 4'd0,
        OP_I         = 4'd1,
        OP_D         = 4'd2,
        OP_N         = 4'd3,
        OP_S         = 4'd4,
        OP_H         = 4'd5,
        OP_P         = 4'd6,
        OP_EQ        = 4'd7,
        OP_X         = 4'd8,
        OP_BAD_FIRST = 4'd9,
        OP_BAD_MID   = 4'd12,
        OP_BAD_LAST  = 4'd15
    } t_op_code;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              tail;
    } t_text_char;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              rec_end;
        bit                typed;
        string             text;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata = '0;   // cigar_word
    logic                s_axis_tlast = 1'b0; // last_of_record
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]   m_axis_tdata;        // text_char
    logic                m_axis_tlast;        // last_of_item

    t_text_char  text_q[$];
    t_row        rows[$];
    int unsigned err_cnt = 0;
    int unsigned cyc = 0;
    int unsigned stall_cnt = 0;

    cigar_word_to_text dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic bit idle_now();
        if (cyc >= STEADY_FROM && cyc < STEADY_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic logic [WORD_W-1:0] pack_op(input logic [RUN_W-1:0] run,
                                                  input t_op_code code);
        return {run, code};
    endfunction

    function automatic logic [CHAR_W-1:0] letter_of(input logic [CODE_W-1:0] code);
        case (t_op_code'(code))
            OP_M:    return "M";
            OP_I:    return "I";
            OP_D:    return "D";
            OP_N:    return "N";
            OP_S:    return "S";
            OP_H:    return "H";
            OP_P:    return "P";
            OP_EQ:   return "=";
            OP_X:    return "X";
            default: return CHAR_NUL;
        endcase
    endfunction

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic void push_char(input logic [CHAR_W-1:0] ch);
        text_q.push_back('{ch: ch, tail: 1'b0});
    endfunction

    // Spell one operation word as run-length digits and letter (codes 0 to 8 only) and optional record terminator.
    function automatic void spell_operation(input logic [WORD_W-1:0] word, input logic rec_end);
        logic [CODE_W-1:0] code;
        int unsigned       v;
        logic [CHAR_W-1:0] digs[DIG_N];
        int                nd;
        int                before_n;
        code     = word[CODE_W-1:0];
        v        = 32'(word[WORD_W-1:CODE_W]);
        nd       = 0;
        before_n = text_q.size();
        if (code < NUM_OPS) begin
            do begin
                digs[nd] = CHAR_W'("0" + v % 10);
                nd++;
                v = v / 10;
            end while (v != 0);
            while (nd > 0) begin
                nd--;
                push_char(digs[nd]);
            end
            push_char(letter_of(code));
        end
        if (rec_end) begin
            push_char(CHAR_NUL);
        end
        if (text_q.size() > before_n) begin
            text_q[$].tail = 1'b1;
        end
    endfunction

    function automatic void expect_typed(input string text, input logic rec_end);
        int before_n;
        before_n = text_q.size();
        for (int k = 0; k < text.len(); k++) begin
            push_char(text[k]);
        end
        if (rec_end) begin
            push_char(CHAR_NUL);
        end
        if (text_q.size() > before_n) begin
            text_q[$].tail = 1'b1;
        end
    endfunction

    // Present one word, hold it until the transfer, then record what it must produce.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic rec_end,
                             input bit typed, input string text);
        while (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= rec_end;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (typed) begin
            expect_typed(text, rec_end);
        end else begin
            spell_operation(word, rec_end);
        end
    endtask

    function automatic logic [WORD_W-1:0] random_op();
        t_op_code    code;
        int unsigned run;
        int unsigned lo;
        int unsigned hi;
        int unsigned ndig;
        if ($urandom_range(99) < 88) begin
            code = t_op_code'($urandom_range(OP_X, OP_M));
        end else begin
            code = t_op_code'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
        end
        if ($urandom_range(9) == 0) begin
            run = $urandom & MAX_RUN;
        end else begin
            ndig = $urandom_range(DIG_N, 1);
            lo   = 1;
            repeat (ndig - 1) lo = lo * 10;
            hi   = (ndig == DIG_N) ? MAX_RUN : lo * 10 - 1;
            run  = $urandom_range(hi, (ndig == 1) ? 0 : lo);
        end
        return pack_op(RUN_W'(run), code);
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt + 1 >= STALL_LIMIT) begin
            $display("cigar_word_to_text regression: fail");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Receive side: check each character transfer, then pick the next ready.
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (text_q.size() == 0) begin
                    report($sformatf("unexpected char %h tlast %b", m_axis_tdata, m_axis_tlast));
                end else begin
                    want = text_q.pop_front();
                    if (m_axis_tdata !== want.ch) begin
                        report($sformatf("char %h, want %h", m_axis_tdata, want.ch));
                    end
                    if (m_axis_tlast !== want.tail) begin
                        report($sformatf("tlast %b on char %h, want %b",
                                         m_axis_tlast, m_axis_tdata, want.tail));
                    end
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    initial begin
        int          sent;
        int          n_ops;
        logic [WORD_W-1:0] word;
        logic        rec_end;

        rows.push_back('{pack_op(0, OP_M),                 1'b0, 1'b1, "0M"});
        rows.push_back('{pack_op(MAX_RUN, OP_M),           1'b1, 1'b1, "268435455M"});
        rows.push_back('{pack_op(1, OP_I),                 1'b0, 1'b1, "1I"});
        rows.push_back('{pack_op(10, OP_D),                1'b0, 1'b1, "10D"});
        rows.push_back('{pack_op(99, OP_N),                1'b0, 1'b1, "99N"});
        rows.push_back('{pack_op(100, OP_S),               1'b0, 1'b1, "100S"});
        rows.push_back('{pack_op(12345, OP_H),             1'b0, 1'b1, "12345H"});
        rows.push_back('{pack_op(7, OP_P),                 1'b0, 1'b1, "7P"});
        rows.push_back('{pack_op(100000000, OP_EQ),        1'b0, 1'b1, "100000000="});
        rows.push_back('{pack_op(9, OP_X),                 1'b1, 1'b1, "9X"});
        rows.push_back('{pack_op(0, OP_X),                 1'b1, 1'b1, "0X"});
        rows.push_back('{pack_op(5, OP_BAD_FIRST),         1'b0, 1'b1, ""});
        rows.push_back('{pack_op(MAX_RUN, OP_BAD_LAST),    1'b1, 1'b1, ""});
        rows.push_back('{pack_op(MAX_RUN, OP_BAD_LAST),    1'b0, 1'b1, ""});
        rows.push_back('{pack_op(0, OP_BAD_MID),           1'b1, 1'b1, ""});
        rows.push_back('{pack_op(99999999, OP_M),          1'b0, 1'b1, "99999999M"});
        rows.push_back('{pack_op(28'h5555555, OP_S),       1'b0, 1'b0, ""});
        rows.push_back('{pack_op(28'hAAAAAAA, OP_D),       1'b1, 1'b0, ""});
        rows.push_back('{pack_op(123456789, OP_EQ),        1'b0, 1'b0, ""});
        rows.push_back('{pack_op(0, OP_BAD_LAST),          1'b0, 1'b0, ""});
        rows.push_back('{pack_op(42, OP_P),                1'b1, 1'b0, ""});

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_word(rows[r].word, rows[r].rec_end, rows[r].typed, rows[r].text);
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            n_ops = $urandom_range(8, 1);
            for (int k = 0; k < n_ops; k++) begin
                if ($urandom_range(99) < 5) begin
                    word    = $urandom;
                    rec_end = 1'($urandom_range(1));
                end else begin
                    word    = random_op();
                    rec_end = (k == n_ops - 1);
                end
                send_word(word, rec_end, 1'b0, "");
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("cigar_word_to_text regression: pass");
        end else begin
            $display("cigar_word_to_text regression: fail");
        end
        $finish;
    end

endmodule
